// ===== sv/btms_pkg.sv =====
`timescale 1ns / 1ps
package btms_pkg;
    localparam logic [7:0] REG_ROWS = 8'd0;
    localparam logic [7:0] REG_COLS = 8'd1;
    localparam logic       ACT_LOAD = 1'b0;
    localparam logic       ACT_FETCH = 1'b1;
    localparam int unsigned HIST_MAX = 32767;
    localparam int unsigned MAJORITY = 5;
    localparam int unsigned HIST_DEPTH = 256;
    localparam int unsigned HIST_W = 15;

    typedef struct packed {
        logic       action;
        logic [7:0] pixel;
    } t_in_item;

    typedef struct packed {
        logic       smoothed;
        logic       two_tone;
        logic [6:0] row_index;
        logic [6:0] col_index;
        logic [7:0] threshold;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [7:0] index;
        logic [7:0] data;
    } t_cfg_item;
endpackage

// ===== sv/btms_if.sv =====
`timescale 1ns / 1ps
interface btms_in_if;
    logic                valid;
    logic                ready;
    btms_pkg::t_in_item  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface btms_out_if;
    logic                valid;
    logic                ready;
    btms_pkg::t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface btms_cfg_if;
    logic                valid;
    logic                ready;
    btms_pkg::t_cfg_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/btms_ram.sv =====
`timescale 1ns / 1ps
module btms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/bimodal_threshold_majority_smoothing_core.sv =====
`timescale 1ns / 1ps
// Load transaction: histogram read-modify-write plus image write (states LRD, LWAIT, LWR), then ready.
// Last load of a frame adds a 256-bin peak scan (states SCAN, SWAIT).
// Fetch transaction: 9 image reads on one read port, then the result is registered.
// End of frame and every write to the row or column register start a histogram clear; loads wait.
// Result sits in an output register; next item taken once delivered.
// Synchronous active-low reset clears control state and starts the histogram clear.
module bimodal_threshold_majority_smoothing_core #(
    parameter int MAX_ROWS = 128,
    parameter int MAX_COLS = 128
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    btms_in_if.sink    i_in,
    btms_out_if.source o_out,
    btms_cfg_if.sink   i_cfg
);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_COLS);
    localparam int AW = RW + CW;
    localparam int HA = $clog2(btms_pkg::HIST_DEPTH);

    localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_LRD = 4'd2, S_LWAIT = 4'd3,
                           S_LWR = 4'd4, S_SCAN = 4'd5, S_SWAIT = 4'd6, S_FRD = 4'd7,
                           S_FDONE = 4'd8, S_OUT = 4'd9;

    logic [3:0]  r_state, n_state;
    logic [7:0]  r_rows, r_cols;
    logic [RW:0] r_nr;
    logic [CW:0] r_nc;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic        r_emit;
    logic [7:0]  r_thr;
    logic [7:0]  r_pix;
    logic [HA:0] r_cnt;      // clear / scan sweep counter
    logic [3:0]  r_k;        // neighbor read index, issue side
    logic [3:0]  r_kd;       // delayed for read data
    logic        r_rv;
    logic        r_center;
    logic [3:0]  r_same;
    logic [7:0]  r_v1, r_v2;
    logic [HA-1:0] r_sidx;
    logic        r_svld;
    logic [btms_pkg::HIST_W-1:0] r_b1, r_b2;
    btms_pkg::t_out_item r_out;
    logic        r_oval;

    // histogram memory
    logic              h_we;
    logic [HA-1:0]     h_waddr, h_raddr;
    logic [btms_pkg::HIST_W-1:0] h_wdata, h_rdata;
    btms_ram #(.WIDTH(btms_pkg::HIST_W), .DEPTH(btms_pkg::HIST_DEPTH)) u_hist (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_waddr), .i_wdata(h_wdata),
        .i_raddr(h_raddr), .o_rdata(h_rdata));

    // image memory, addressed as {row, col}
    logic          m_we;
    logic [AW-1:0] m_waddr, m_raddr;
    logic [7:0]    m_rdata;
    btms_ram #(.WIDTH(8), .DEPTH(1 << AW)) u_img (
        .i_clk(i_clk), .i_we(m_we), .i_waddr(m_waddr), .i_wdata(r_pix),
        .i_raddr(m_raddr), .o_rdata(m_rdata));

    // clamped dimensions from registers
    logic [RW:0] w_nr;
    logic [CW:0] w_nc;
    always_comb begin
        w_nr = (r_rows == 8'd0) ? (RW+1)'(1) :
               ({24'd0, r_rows} > MAX_ROWS) ? (RW+1)'(MAX_ROWS) : (RW+1)'(r_rows);
        w_nc = (r_cols == 8'd0) ? (CW+1)'(1) :
               ({24'd0, r_cols} > MAX_COLS) ? (CW+1)'(MAX_COLS) : (CW+1)'(r_cols);
    end

    wire w_lastcol = ({1'b0, r_col} == r_nc - 1'b1);
    wire w_lastrow = ({1'b0, r_row} == r_nr - 1'b1);

    // neighbor coordinates for index r_k (0 = center, then 8 neighbors)
    logic [RW-1:0] w_nrow;
    logic [CW-1:0] w_ncol;
    logic [1:0]    w_dr, w_dc;
    always_comb begin
        case (r_k)
            4'd0: begin w_dr = 2'd1; w_dc = 2'd1; end
            4'd1: begin w_dr = 2'd0; w_dc = 2'd0; end
            4'd2: begin w_dr = 2'd0; w_dc = 2'd1; end
            4'd3: begin w_dr = 2'd0; w_dc = 2'd2; end
            4'd4: begin w_dr = 2'd1; w_dc = 2'd0; end
            4'd5: begin w_dr = 2'd1; w_dc = 2'd2; end
            4'd6: begin w_dr = 2'd2; w_dc = 2'd0; end
            4'd7: begin w_dr = 2'd2; w_dc = 2'd1; end
            4'd8: begin w_dr = 2'd2; w_dc = 2'd2; end
            default: begin w_dr = 2'd1; w_dc = 2'd1; end
        endcase
        w_nrow = r_row;
        if (w_dr == 2'd0 && r_row != '0) w_nrow = r_row - 1'b1;
        if (w_dr == 2'd2 && !w_lastrow) w_nrow = r_row + 1'b1;
        w_ncol = r_col;
        if (w_dc == 2'd0 && r_col != '0) w_ncol = r_col - 1'b1;
        if (w_dc == 2'd2 && !w_lastcol) w_ncol = r_col + 1'b1;
    end

    wire w_tone = (m_rdata <= r_thr);
    wire w_in_acc = i_in.valid && i_in.ready;
    wire w_cfg_acc = i_cfg.valid && i_cfg.ready;
    wire w_cfg_hit = w_cfg_acc && (i_cfg.payload.index == btms_pkg::REG_ROWS ||
                                   i_cfg.payload.index == btms_pkg::REG_COLS);

    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_oval;
    assign o_out.payload = r_out;

    always_comb begin
        h_we = 1'b0; h_waddr = r_pix; h_wdata = h_rdata + 1'b1;
        h_raddr = r_pix;
        m_we = 1'b0; m_waddr = {r_row, r_col};
        m_raddr = {w_nrow, w_ncol};
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                h_we = 1'b1; h_waddr = r_cnt[HA-1:0]; h_wdata = '0;
                if (r_cnt[HA]) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in.payload.action == btms_pkg::ACT_LOAD && !r_emit)
                        n_state = S_LRD;
                    else if (i_in.payload.action == btms_pkg::ACT_FETCH && r_emit)
                        n_state = S_FRD;
                end
            end
            S_LRD: n_state = S_LWAIT;
            S_LWAIT: n_state = S_LWR;
            S_LWR: begin
                m_we = 1'b1;
                h_we = (r_pix != 8'd0) && (h_rdata != btms_pkg::HIST_W'(btms_pkg::HIST_MAX));
                n_state = (w_lastrow && w_lastcol) ? S_SCAN : S_IDLE;
            end
            S_SCAN: begin
                h_raddr = r_cnt[HA-1:0];
                if (r_cnt[HA]) n_state = S_SWAIT;
            end
            S_SWAIT: n_state = S_IDLE;
            S_FRD: if (r_k == 4'd8) n_state = S_FDONE;
            // last neighbor is folded in on the first FDONE cycle
            S_FDONE: if (!r_rv) n_state = S_OUT;
            S_OUT: if (o_out.ready) n_state = (r_out.last) ? S_CLEAR : S_IDLE;
            default: n_state = S_IDLE;
        endcase
        if (w_cfg_hit) n_state = S_CLEAR;
    end

    always_ff @(posedge i_clk) begin
        r_rv <= 1'b0;
        r_svld <= 1'b0;
        r_sidx <= r_cnt[HA-1:0];
        r_kd <= r_k;
        case (r_state)
            S_IDLE: begin
                r_pix <= i_in.payload.pixel;
                r_k <= '0;
                r_same <= '0;
            end
            S_SCAN: begin
                r_svld <= !r_cnt[HA];
            end
            S_FRD: begin
                r_rv <= 1'b1;
                r_k <= r_k + 1'b1;
            end
            default: ;
        endcase
        if (r_rv) begin
            if (r_kd == 4'd0) r_center <= w_tone;
            else if (w_tone == r_center) r_same <= r_same + 1'b1;
        end
        if (r_state == S_FDONE && n_state == S_OUT) begin
            r_out.two_tone  <= r_center;
            r_out.smoothed  <= (r_same >= 4'(btms_pkg::MAJORITY)) ? r_center : !r_center;
            r_out.row_index <= 7'(r_row);
            r_out.col_index <= 7'(r_col);
            r_out.threshold <= r_thr;
            r_out.last      <= w_lastrow && w_lastcol;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_rows <= 8'd1; r_cols <= 8'd1;
            r_nr <= (RW+1)'(1); r_nc <= (CW+1)'(1);
            r_row <= '0; r_col <= '0;
            r_emit <= 1'b0;
            r_thr <= '0;
            r_cnt <= '0;
            r_oval <= 1'b0;
            r_v1 <= '0; r_v2 <= '0; r_b1 <= '0; r_b2 <= '0;
        end else begin
            r_state <= n_state;
            r_nr <= w_nr;
            r_nc <= w_nc;
            if (r_state == S_CLEAR || r_state == S_SCAN) r_cnt <= r_cnt + 1'b1;
            if (r_state == S_LWR && w_lastrow && w_lastcol) begin
                r_cnt <= '0;
                r_v1 <= '0; r_v2 <= '0; r_b1 <= '0; r_b2 <= '0;
            end
            if (r_state == S_LWR) begin
                if (w_lastcol) begin
                    r_col <= '0;
                    r_row <= w_lastrow ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (r_svld) begin
                if (!r_sidx[HA-1]) begin
                    if (r_sidx != '0 && h_rdata > r_b1) begin
                        r_b1 <= h_rdata; r_v1 <= r_sidx;
                    end
                end else if (h_rdata > r_b2) begin
                    r_b2 <= h_rdata; r_v2 <= r_sidx;
                end
            end
            if (r_state == S_SWAIT) begin
                r_thr <= 8'(({1'b0, r_v1} + {1'b0, r_v2}) >> 1);
                r_emit <= 1'b1;
            end
            if (r_state == S_FDONE && n_state == S_OUT) r_oval <= 1'b1;
            if (r_state == S_OUT && o_out.ready) begin
                r_oval <= 1'b0;
                if (r_out.last) begin
                    r_emit <= 1'b0;
                    r_cnt <= '0;
                    r_row <= '0; r_col <= '0;
                end else if (w_lastcol) begin
                    r_col <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (w_cfg_hit) begin
                if (i_cfg.payload.index == btms_pkg::REG_ROWS) r_rows <= i_cfg.payload.data;
                else r_cols <= i_cfg.payload.data;
                r_cnt <= '0;
                r_row <= '0; r_col <= '0;
                r_emit <= 1'b0;
                r_oval <= 1'b0;
            end
        end
    end
endmodule

// ===== tb/sv/bimodal_threshold_majority_smoothing_core_tb.sv =====
`timescale 1ns / 1ps
module bimodal_threshold_majority_smoothing_core_tb;

    localparam int N_MAX = 128;
    localparam int STALL_LIMIT = 20000;

    // Collects expected output pixels and checks delivered ones against them.
    class pixel_scoreboard;
        btms_pkg::t_out_item pending[$];
        int errors;

        function void note_input(btms_pkg::t_out_item exp_px);
            pending.push_back(exp_px);
        endfunction

        function void check_result(btms_pkg::t_out_item got);
            btms_pkg::t_out_item exp_px;
            if (pending.size() == 0) begin
                $error("unexpected result %h", got);
                errors++;
                return;
            end
            exp_px = pending.pop_front();
            if (got.smoothed !== exp_px.smoothed) begin
                $error("smoothed exp %0d got %0d", exp_px.smoothed, got.smoothed);
                errors++;
            end
            if (got.two_tone !== exp_px.two_tone) begin
                $error("two_tone exp %0d got %0d", exp_px.two_tone, got.two_tone);
                errors++;
            end
            if (got.row_index !== exp_px.row_index) begin
                $error("row_index exp %0d got %0d", exp_px.row_index, got.row_index);
                errors++;
            end
            if (got.col_index !== exp_px.col_index) begin
                $error("col_index exp %0d got %0d", exp_px.col_index, got.col_index);
                errors++;
            end
            if (got.threshold !== exp_px.threshold) begin
                $error("threshold exp %0d got %0d", exp_px.threshold, got.threshold);
                errors++;
            end
            if (got.last !== exp_px.last) begin
                $error("last exp %0d got %0d", exp_px.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    btms_in_if  in_ch();
    btms_out_if out_ch();
    btms_cfg_if cfg_ch();

    bimodal_threshold_majority_smoothing_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_cfg(cfg_ch.sink)
    );

    pixel_scoreboard sb = new();

    // predictor state
    logic [7:0]  img [N_MAX*N_MAX];
    int unsigned hist [256];
    int unsigned n_loaded;
    int unsigned n_emitted;
    logic [7:0]  thr;
    bit          emitting;
    logic [7:0]  reg_rows = 8'd1;
    logic [7:0]  reg_cols = 8'd1;
    int          stall_cnt;
    bit          rx_stall_long;

    function automatic int clamp_dim(logic [7:0] v);
        if (v == 0) return 1;
        if (v > N_MAX) return N_MAX;
        return v;
    endfunction

    function automatic void restart_frame();
        foreach (hist[k]) hist[k] = 0;
        n_loaded = 0;
        n_emitted = 0;
        emitting = 1'b0;
    endfunction

    function automatic bit tone(int r, int c, int nr, int nc);
        if (r < 0) r = 0;
        if (r > nr - 1) r = nr - 1;
        if (c < 0) c = 0;
        if (c > nc - 1) c = nc - 1;
        return img[r*N_MAX + c] <= thr;
    endfunction

    function automatic logic [7:0] peak_threshold();
        int unsigned b1, b2, v1, v2;
        b1 = 0; b2 = 0; v1 = 0; v2 = 0;
        for (int v = 1; v < 128; v++) if (hist[v] > b1) begin b1 = hist[v]; v1 = v; end
        for (int v = 128; v < 256; v++) if (hist[v] > b2) begin b2 = hist[v]; v2 = v; end
        return 8'((v1 + v2) / 2);
    endfunction

    // returns 1 when the transaction yields an output pixel
    function automatic bit predict_pixel(btms_pkg::t_in_item it,
                                         output btms_pkg::t_out_item px);
        int nr, nc, i, j, same;
        bit ctr;
        nr = clamp_dim(reg_rows);
        nc = clamp_dim(reg_cols);
        px = '0;
        if (it.action == btms_pkg::ACT_LOAD) begin
            if (emitting) return 0;
            img[(n_loaded / nc)*N_MAX + n_loaded % nc] = it.pixel;
            if (it.pixel != 0 && hist[it.pixel] < btms_pkg::HIST_MAX) hist[it.pixel]++;
            n_loaded++;
            if (n_loaded >= nr*nc) begin
                thr = peak_threshold();
                n_emitted = 0;
                emitting = 1'b1;
            end
            return 0;
        end
        if (!emitting) return 0;
        i = n_emitted / nc;
        j = n_emitted % nc;
        ctr = tone(i, j, nr, nc);
        same = 0;
        for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
                if ((dr != 0 || dc != 0) && tone(i+dr, j+dc, nr, nc) == ctr) same++;
        px.smoothed = (same >= btms_pkg::MAJORITY) ? ctr : ~ctr;
        px.two_tone = ctr;
        px.row_index = i[6:0];
        px.col_index = j[6:0];
        px.threshold = thr;
        px.last = (n_emitted + 1 >= nr*nc);
        n_emitted++;
        if (px.last) restart_frame();
        return 1;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    initial begin
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.payload = '0;
        out_ch.ready = 1'b0;
    end

    // result side: random backpressure, check every delivered pixel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.payload);
            if ($urandom_range(0, 99) < 3) rx_stall_long <= ~rx_stall_long;
            out_ch.ready <= rx_stall_long ? ($urandom_range(0, 9) == 0)
                                          : ($urandom_range(0, 3) != 0);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready) || !i_rst_n)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt > STALL_LIMIT) begin
            $display("bimodal_threshold_majority_smoothing_core_tb NOT OK");
            $finish;
        end
    end

    // valid stays high across back-to-back transactions; drain() drops it
    task automatic send_item(bit act, logic [7:0] pix);
        btms_pkg::t_in_item it;
        btms_pkg::t_out_item px;
        int g;
        g = gap_len();
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        it.action = act;
        it.pixel = pix;
        in_ch.valid <= 1'b1;
        in_ch.payload <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (predict_pixel(it, px)) sb.note_input(px);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [7:0] val);
        btms_pkg::t_cfg_item c;
        drain();
        c.index = idx;
        c.data = val;
        cfg_ch.valid <= 1'b1;
        cfg_ch.payload <= c;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        if (idx == btms_pkg::REG_ROWS) reg_rows = val;
        else if (idx == btms_pkg::REG_COLS) reg_cols = val;
        if (idx == btms_pkg::REG_ROWS || idx == btms_pkg::REG_COLS) restart_frame();
        repeat (300) @(posedge i_clk);
    endtask

    function automatic logic [7:0] bimodal_pixel();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) return 8'($urandom_range(0, 255));
        if (p < 5) return 8'($urandom_range(20, 70));
        return 8'($urandom_range(160, 230));
    endfunction

    // one whole frame with random content, a stray fetch or extra load now and then
    task automatic run_frame(int nr, int nc);
        for (int k = 0; k < nr*nc; k++) begin
            if ($urandom_range(0, 19) == 0)
                send_item(btms_pkg::ACT_FETCH, 8'($urandom_range(0, 255)));
            send_item(btms_pkg::ACT_LOAD, bimodal_pixel());
        end
        for (int k = 0; k < nr*nc; k++) begin
            if ($urandom_range(0, 19) == 0)
                send_item(btms_pkg::ACT_LOAD, 8'($urandom_range(0, 255)));
            send_item(btms_pkg::ACT_FETCH, 8'($urandom_range(0, 255)));
        end
    endtask

    int done;
    int nr, nc;

    initial begin
        restart_frame();
        thr = '0;
        foreach (img[k]) img[k] = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: 1x1 default frame, early fetch, extremes, empty ranges
        send_item(btms_pkg::ACT_FETCH, 8'hFF);
        send_item(btms_pkg::ACT_LOAD, 8'h00);
        send_item(btms_pkg::ACT_LOAD, 8'hFF);
        send_item(btms_pkg::ACT_FETCH, 8'h00);
        send_item(btms_pkg::ACT_LOAD, 8'hFF);
        send_item(btms_pkg::ACT_FETCH, 8'hAA);
        write_reg(btms_pkg::REG_ROWS, 8'd3);
        write_reg(btms_pkg::REG_COLS, 8'd3);
        write_reg(8'd2, 8'd7);
        send_item(btms_pkg::ACT_LOAD, 8'd127);
        send_item(btms_pkg::ACT_LOAD, 8'd128);
        send_item(btms_pkg::ACT_LOAD, 8'd1);
        send_item(btms_pkg::ACT_LOAD, 8'd128);
        send_item(btms_pkg::ACT_LOAD, 8'd127);
        send_item(btms_pkg::ACT_LOAD, 8'd255);
        send_item(btms_pkg::ACT_LOAD, 8'd0);
        send_item(btms_pkg::ACT_LOAD, 8'd128);
        send_item(btms_pkg::ACT_LOAD, 8'd55);
        repeat (9) send_item(btms_pkg::ACT_FETCH, 8'h00);
        // out-of-range dimensions act as the nearest legal value
        write_reg(btms_pkg::REG_ROWS, 8'd0);
        write_reg(btms_pkg::REG_COLS, 8'd2);
        run_frame(1, 2);
        write_reg(btms_pkg::REG_ROWS, 8'd255);
        write_reg(btms_pkg::REG_COLS, 8'd1);
        run_frame(128, 1);
        write_reg(btms_pkg::REG_ROWS, 8'd1);
        write_reg(btms_pkg::REG_COLS, 8'd128);
        run_frame(1, 128);

        // random part: mostly small frames
        done = 0;
        while (done < 450) begin
            nr = $urandom_range(1, 12);
            nc = $urandom_range(1, 12);
            if ($urandom_range(0, 1)) write_reg(btms_pkg::REG_ROWS, nr[7:0]);
            else write_reg(btms_pkg::REG_COLS, nc[7:0]);
            write_reg(btms_pkg::REG_ROWS, nr[7:0]);
            write_reg(btms_pkg::REG_COLS, nc[7:0]);
            if ($urandom_range(0, 3) == 0) begin
                // aborted frame: partial load then restart
                for (int k = 0; k < (nr*nc)/2; k++)
                    send_item(btms_pkg::ACT_LOAD, bimodal_pixel());
                done += (nr*nc)/2;
                continue;
            end
            run_frame(nr, nc);
            done += 2*nr*nc;
        end
        // tall narrow frame of two alternating values
        write_reg(btms_pkg::REG_ROWS, 8'd128);
        write_reg(btms_pkg::REG_COLS, 8'd3);
        for (int k = 0; k < 384; k++)
            send_item(btms_pkg::ACT_LOAD, (k % 2) ? 8'd200 : 8'd30);
        drain();
        for (int k = 0; k < 384; k++) send_item(btms_pkg::ACT_FETCH, 8'd0);

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("bimodal_threshold_majority_smoothing_core_tb OK");
        else
            $display("bimodal_threshold_majority_smoothing_core_tb NOT OK");
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/btms_pkg.sv
sv/btms_if.sv
sv/btms_ram.sv
sv/bimodal_threshold_majority_smoothing_core.sv
tb/sv/bimodal_threshold_majority_smoothing_core_tb.sv
